// ===== sv/svrw_pkg.sv =====
// shared types and constants for the stereo volume register writer
// no dependencies; imported by every module of the block
package svrw_pkg;

    localparam int NUM_SOURCES_DEF = 6;
    localparam int SRC_W           = 3;
    localparam int LEVEL_IN_W      = 8;
    localparam int LEVEL_W         = 7;
    localparam int CODE_W          = 7;
    localparam int BYTE_W          = 8;
    localparam int SWAP_W          = 6;
    localparam int S_TDATA_W       = 24;
    localparam int M_TDATA_W       = 24;

    localparam logic [LEVEL_W-1:0] LEVEL_MAX = 7'd100;
    localparam logic [BYTE_W-1:0]  ROUTE_A   = 8'd1;
    localparam logic [BYTE_W-1:0]  ROUTE_B   = 8'd2;

    typedef enum logic [1:0] {
        PORT_SELECT = 2'd0,
        PORT_DATA   = 2'd1,
        PORT_REPORT = 2'd2
    } port_t;

    typedef enum logic {
        CMD_SET  = 1'b0,
        CMD_READ = 1'b1
    } cmd_t;

    typedef struct packed {
        logic               do_set;
        logic [SRC_W-1:0]   src;
        logic               swap;
        logic [LEVEL_W-1:0] rep_left;
        logic [LEVEL_W-1:0] rep_right;
    } start_info_t;

    typedef struct packed {
        logic [LEVEL_W-1:0] level;
        logic [CODE_W-1:0]  code;
    } lane_out_t;

endpackage

// ===== sv/stereo_volume_register_writer_unit.sv =====
// A request on the s_ channel either sets the left and right levels of one mixer source
// (clamped to 100, stored, and turned into eight port writes on the m_ channel: select,
// routing, attenuation select and attenuation code, left then right) or reads back the
// stored levels as a single report result; a source outside the mixer gives a zeroed
// report. The sequencer steps one write per cycle into the single output register while
// the m_ side does not stall, and lets the next request in while the last result still
// waits. Levels reset to zero, swap_mask to zero.
// top level; depends on svrw_pkg, svrw_lane and svrw_sequencer
module stereo_volume_register_writer_unit import svrw_pkg::*; #(
    parameter int NUM_SOURCES = NUM_SOURCES_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic [SWAP_W-1:0]    cfg_wr_data,   // swap_mask
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,       // source[2:0], left_level[10:3], right_level[18:11]
    input  logic                 s_tuser,       // command
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,       // write_value[7:0], stored_left[14:8], stored_right[21:15]
    output logic [1:0]           m_tuser,       // port
    output logic                 m_tlast
);

    localparam int IDX_W = (NUM_SOURCES > 1) ? $clog2(NUM_SOURCES) : 1;

    logic [SWAP_W-1:0]       swap_mask_reg;
    logic [2*LEVEL_W-1:0]    store_reg [NUM_SOURCES];

    logic                    accept;
    logic                    busy;
    logic [SRC_W-1:0]        src;
    logic [IDX_W-1:0]        idx;
    logic                    in_range;
    logic [2*LEVEL_W-1:0]    stored;
    logic [7:0]              swap_ext;
    logic [LEVEL_W-1:0]      l_clamped;
    logic [LEVEL_W-1:0]      r_clamped;
    lane_out_t               lane_l;
    lane_out_t               lane_r;
    start_info_t             info;

    assign s_tready = !busy;
    assign accept   = s_tvalid && s_tready;
    assign src      = s_tdata[SRC_W-1:0];
    assign idx      = src[IDX_W-1:0];
    assign in_range = {1'b0, src} < 4'(NUM_SOURCES);
    assign stored   = in_range ? store_reg[idx] : '0;
    assign swap_ext = {2'b00, swap_mask_reg};

    assign info.do_set    = in_range && (s_tuser == CMD_SET);
    assign info.src       = src;
    assign info.swap      = swap_ext[src];
    assign info.rep_left  = stored[LEVEL_W-1:0];
    assign info.rep_right = stored[2*LEVEL_W-1:LEVEL_W];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            swap_mask_reg <= '0;
            for (int i = 0; i < NUM_SOURCES; i++) begin
                store_reg[i] <= '0;
            end
        end else begin
            if (cfg_wr_en) begin
                swap_mask_reg <= cfg_wr_data;
            end
            for (int i = 0; i < NUM_SOURCES; i++) begin
                if (accept && info.do_set && idx == IDX_W'(i)) begin
                    store_reg[i] <= {r_clamped, l_clamped};
                end
            end
        end
    end

    svrw_lane u_lane_left (
        .aclk     (aclk),
        .load     (accept),
        .level_in (s_tdata[10:3]),
        .clamped  (l_clamped),
        .result   (lane_l)
    );

    svrw_lane u_lane_right (
        .aclk     (aclk),
        .load     (accept),
        .level_in (s_tdata[18:11]),
        .clamped  (r_clamped),
        .result   (lane_r)
    );

    svrw_sequencer u_sequencer (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (accept),
        .info     (info),
        .lane_l   (lane_l),
        .lane_r   (lane_r),
        .busy     (busy),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

// ===== sv/svrw_lane.sv =====
// one channel lane: clamps a level, scales it to 0..31 and builds the attenuation code
// depends on svrw_pkg
module svrw_lane import svrw_pkg::*; (
    input  logic                  aclk,
    input  logic                  load,
    input  logic [LEVEL_IN_W-1:0] level_in,
    output logic [LEVEL_W-1:0]    clamped,
    output lane_out_t             result
);

    logic [11:0]        scaled_in;
    logic [22:0]        product;
    logic [4:0]         s_next;
    logic [4:0]         s_reg;
    logic [LEVEL_W-1:0] level_reg;
    logic [2:0]         expo;
    logic [3:0]         mant;

    assign clamped   = (level_in > LEVEL_IN_W'(LEVEL_MAX)) ? LEVEL_MAX : level_in[LEVEL_W-1:0];
    assign scaled_in = 12'(clamped) * 12'd31 + 12'd50;
    // divide by 100 through the reciprocal 1311 / 2^17, exact below 3200
    assign product   = 23'(scaled_in) * 23'd1311;
    assign s_next    = product[21:17];

    always_ff @(posedge aclk) begin
        if (load) begin
            s_reg     <= s_next;
            level_reg <= clamped;
        end
    end

    always_comb begin
        expo = 3'd0;
        mant = 4'd0;
        if (s_reg[4]) begin
            expo = 3'd7;
            mant = s_reg[3:0];
        end else if (s_reg[3]) begin
            expo = 3'd6;
            mant = {s_reg[2:0], 1'b0};
        end else if (s_reg[2]) begin
            expo = 3'd5;
            mant = {s_reg[1:0], 2'b00};
        end else if (s_reg[1]) begin
            expo = 3'd4;
            mant = {s_reg[0], 3'b000};
        end else if (s_reg[0]) begin
            expo = 3'd3;
            mant = 4'd0;
        end
    end

    assign result.level = level_reg;
    assign result.code  = {expo, mant};

endmodule

// ===== sv/svrw_sequencer.sv =====
// merge stage: steps through the eight port writes of a set or one report result
// depends on svrw_pkg; fed by the two svrw_lane instances
module svrw_sequencer import svrw_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 start,
    input  start_info_t          info,
    input  lane_out_t            lane_l,
    input  lane_out_t            lane_r,
    output logic                 busy,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,
    output logic [1:0]           m_tuser,
    output logic                 m_tlast
);

    logic               active_reg;
    logic               set_reg;
    logic [2:0]         step_reg;
    logic [SRC_W-1:0]   src_reg;
    logic               swap_reg;
    logic [LEVEL_W-1:0] rep_l_reg;
    logic [LEVEL_W-1:0] rep_r_reg;

    logic               out_valid_reg;
    port_t              out_port_reg;
    logic [BYTE_W-1:0]  out_val_reg;
    logic [LEVEL_W-1:0] out_l_reg;
    logic [LEVEL_W-1:0] out_r_reg;
    logic               out_last_reg;

    logic               load;
    logic               final_step;
    port_t              port_next;
    logic [BYTE_W-1:0]  val_next;
    logic [BYTE_W-1:0]  route;
    logic [CODE_W-1:0]  code;

    assign load       = active_reg && (!out_valid_reg || m_tready);
    assign final_step = !set_reg || (step_reg == 3'd7);

    always_comb begin
        code  = step_reg[2] ? lane_r.code : lane_l.code;
        route = (step_reg[2] ^ swap_reg) ? ROUTE_B : ROUTE_A;
        if (!set_reg) begin
            port_next = PORT_REPORT;
            val_next  = '0;
        end else if (!step_reg[0]) begin
            port_next = PORT_SELECT;
            val_next  = {2'b00, src_reg, 1'b0, step_reg[1], step_reg[2]};
        end else begin
            port_next = PORT_DATA;
            val_next  = step_reg[1] ? BYTE_W'(code) : route;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg    <= 1'b0;
            set_reg       <= 1'b0;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (start) begin
                active_reg <= 1'b1;
                step_reg   <= '0;
                set_reg    <= info.do_set;
            end else if (load) begin
                if (final_step) begin
                    active_reg <= 1'b0;
                    step_reg   <= '0;
                end else begin
                    step_reg <= step_reg + 3'd1;
                end
            end
            if (load) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            src_reg   <= info.src;
            swap_reg  <= info.swap;
            rep_l_reg <= info.rep_left;
            rep_r_reg <= info.rep_right;
        end
        if (load) begin
            out_port_reg <= port_next;
            out_val_reg  <= val_next;
            out_l_reg    <= set_reg ? lane_l.level : rep_l_reg;
            out_r_reg    <= set_reg ? lane_r.level : rep_r_reg;
            out_last_reg <= final_step;
        end
    end

    assign busy     = active_reg;
    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_port_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {2'b00, out_r_reg, out_l_reg, out_val_reg};

    a_start_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        start |=> busy)
        else $error("sequencer not busy after a request was taken");

    a_report_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser == PORT_REPORT) |-> m_tlast)
        else $error("report result without last");

    a_step_active: assert property (@(posedge aclk) disable iff (!aresetn)
        (step_reg != 3'd0) |-> (active_reg && set_reg))
        else $error("step counter running outside a set");

    a_set_ends_data: assert property (@(posedge aclk) disable iff (!aresetn)
        (load && set_reg && step_reg == 3'd7) |=> (m_tlast && m_tuser == PORT_DATA))
        else $error("set sequence does not end on a data write");

endmodule

// ===== sim/svrw_write_checker.sv =====
// checker for the stereo volume register writer: watches the request, result and
// configuration ports, predicts every port write and compares it with what arrives
// depends on svrw_pkg
module svrw_write_checker import svrw_pkg::*; #(
    parameter int NUM_SOURCES = NUM_SOURCES_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic [SWAP_W-1:0]    cfg_wr_data,
    input  logic                 s_tvalid,
    input  logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,
    input  logic                 s_tuser,
    input  logic                 m_tvalid,
    input  logic                 m_tready,
    input  logic [M_TDATA_W-1:0] m_tdata,
    input  logic [1:0]           m_tuser,
    input  logic                 m_tlast,
    output int                   pending_writes,
    output int                   mismatches
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        port_t              port;
        logic [BYTE_W-1:0]  value;
        logic [LEVEL_W-1:0] left;
        logic [LEVEL_W-1:0] right;
        logic               last;
    } port_write_t;

    port_write_t        expected_writes[$];
    logic [SWAP_W-1:0]  swap_mask;
    logic [LEVEL_W-1:0] left_store [NUM_SOURCES];
    logic [LEVEL_W-1:0] right_store[NUM_SOURCES];
    int                 mismatch_count = 0;
    int                 pending_count  = 0;

    assign mismatches     = mismatch_count;
    assign pending_writes = pending_count;

    function automatic logic [LEVEL_W-1:0] clamp_level(logic [LEVEL_IN_W-1:0] requested);
        return (requested > LEVEL_IN_W'(LEVEL_MAX)) ? LEVEL_MAX : requested[LEVEL_W-1:0];
    endfunction

    function automatic logic [BYTE_W-1:0] atten_code_of(logic [LEVEL_W-1:0] level);
        int unsigned scaled;
        int unsigned exponent;
        scaled = (31 * int'(level) + 50) / 100;
        if (scaled == 0) begin
            return '0;
        end
        exponent = 7;
        while (scaled < 16) begin
            scaled = scaled << 1;
            exponent--;
        end
        return BYTE_W'((exponent << 4) + (scaled - 16));
    endfunction

    task automatic push_write(port_t port, logic [BYTE_W-1:0] value,
                              logic [LEVEL_W-1:0] left, logic [LEVEL_W-1:0] right,
                              logic last);
        port_write_t w;
        w.port  = port;
        w.value = value;
        w.left  = left;
        w.right = right;
        w.last  = last;
        expected_writes.push_back(w);
    endtask

    task automatic predict_request(cmd_t cmd, logic [SRC_W-1:0] src,
                                   logic [LEVEL_IN_W-1:0] left_req,
                                   logic [LEVEL_IN_W-1:0] right_req);
        logic [LEVEL_W-1:0] l;
        logic [LEVEL_W-1:0] r;
        logic [BYTE_W-1:0]  base;
        logic [BYTE_W-1:0]  left_sel;
        logic [BYTE_W-1:0]  right_sel;
        logic               swapped;
        if (int'(src) >= NUM_SOURCES) begin
            push_write(PORT_REPORT, '0, '0, '0, 1'b1);
        end else if (cmd == CMD_READ) begin
            push_write(PORT_REPORT, '0, left_store[src], right_store[src], 1'b1);
        end else begin
            l = clamp_level(left_req);
            r = clamp_level(right_req);
            left_store[src]  = l;
            right_store[src] = r;
            swapped = 1'b0;
            if (int'(src) < SWAP_W) begin
                swapped = swap_mask[src];
            end
            left_sel  = swapped ? ROUTE_B : ROUTE_A;
            right_sel = swapped ? ROUTE_A : ROUTE_B;
            base = {2'b00, src, 3'b000};
            push_write(PORT_SELECT, base | 8'h00, l, r, 1'b0);
            push_write(PORT_DATA, left_sel, l, r, 1'b0);
            push_write(PORT_SELECT, base | 8'h02, l, r, 1'b0);
            push_write(PORT_DATA, atten_code_of(l), l, r, 1'b0);
            push_write(PORT_SELECT, base | 8'h01, l, r, 1'b0);
            push_write(PORT_DATA, right_sel, l, r, 1'b0);
            push_write(PORT_SELECT, base | 8'h03, l, r, 1'b0);
            push_write(PORT_DATA, atten_code_of(r), l, r, 1'b1);
        end
    endtask

    task automatic check_field(string name, int unsigned expected, int unsigned actual);
        if (expected != actual) begin
            $error("%s: expected %0d, got %0d", name, expected, actual);
            mismatch_count++;
        end
    endtask

    always @(posedge aclk) begin
        port_write_t exp_w;
        if (!aresetn) begin
            swap_mask = '0;
            for (int i = 0; i < NUM_SOURCES; i++) begin
                left_store[i]  = '0;
                right_store[i] = '0;
            end
            expected_writes.delete();
        end else begin
            if (cfg_wr_en) begin
                swap_mask = cfg_wr_data;
            end
            if (s_tvalid && s_tready) begin
                predict_request(cmd_t'(s_tuser), s_tdata[2:0], s_tdata[10:3], s_tdata[18:11]);
            end
            if (m_tvalid && m_tready) begin
                if (expected_writes.size() == 0) begin
                    $error("unexpected port write: port %0d value %0d", m_tuser, m_tdata[7:0]);
                    mismatch_count++;
                end else begin
                    exp_w = expected_writes.pop_front();
                    check_field("port", exp_w.port, m_tuser);
                    check_field("write_value", exp_w.value, m_tdata[7:0]);
                    check_field("stored_left", exp_w.left, m_tdata[14:8]);
                    check_field("stored_right", exp_w.right, m_tdata[21:15]);
                    check_field("last", exp_w.last, m_tlast);
                end
            end
        end
        pending_count <= expected_writes.size();
    end

endmodule

// ===== sim/tb_stereo_volume_register_writer_unit.sv =====
// top of the stereo volume register writer testbench: clock, reset, directed and
// random requests, swap mask phases, random stalls and the verdict
// depends on svrw_pkg, stereo_volume_register_writer_unit and svrw_write_checker
module tb_stereo_volume_register_writer_unit;
    timeunit 1ns;
    timeprecision 1ps;
    import svrw_pkg::*;

    localparam int IDLE_LIMIT   = 1000;
    localparam int DRAIN_CYCLES = 12;

    logic                 aclk        = 1'b0;
    logic                 aresetn     = 1'b0;
    logic                 cfg_wr_en   = 1'b0;
    logic [SWAP_W-1:0]    cfg_wr_data = '0;
    logic                 s_tvalid    = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata     = '0;
    logic                 s_tuser     = 1'b0;
    logic                 m_tvalid;
    logic                 m_tready    = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [1:0]           m_tuser;
    logic                 m_tlast;
    logic                 quiet       = 1'b0;
    int                   idle_cycles = 0;
    int                   pending_writes;
    int                   mismatches;

    always #5 aclk = ~aclk;

    stereo_volume_register_writer_unit DUT (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast)
    );

    svrw_write_checker u_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .s_tuser       (s_tuser),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tuser       (m_tuser),
        .m_tlast       (m_tlast),
        .pending_writes(pending_writes),
        .mismatches    (mismatches)
    );

    always @(posedge aclk) begin
        m_tready <= quiet || ($urandom_range(99) >= 6);
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        do @(posedge aclk); while (idle_cycles < IDLE_LIMIT);
        $display("tb_stereo_volume_register_writer_unit: FAIL");
        $finish;
    end

    task automatic send_request(cmd_t cmd, logic [SRC_W-1:0] src,
                                logic [LEVEL_IN_W-1:0] left_req,
                                logic [LEVEL_IN_W-1:0] right_req);
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {5'b0, right_req, left_req, src};
        do @(posedge aclk); while (!s_tready);
        if (!quiet && $urandom_range(99) < 6) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(4, 1)) @(posedge aclk);
        end
    endtask

    task automatic wait_drained();
        if (s_tvalid) begin
            s_tvalid <= 1'b0;
        end
        @(posedge aclk);
        while (pending_writes != 0) @(posedge aclk);
    endtask

    task automatic write_swap_mask(logic [SWAP_W-1:0] mask);
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= mask;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
    endtask

    function automatic logic [LEVEL_IN_W-1:0] random_level();
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 70) begin
            return LEVEL_IN_W'($urandom_range(100));
        end else if (pick < 85) begin
            return LEVEL_IN_W'($urandom_range(255, 101));
        end
        return LEVEL_IN_W'($urandom_range(255));
    endfunction

    task automatic send_random(int count);
        cmd_t             cmd;
        logic [SRC_W-1:0] src;
        for (int i = 0; i < count; i++) begin
            cmd = ($urandom_range(99) < 30) ? CMD_READ : CMD_SET;
            if ($urandom_range(9) == 0) begin
                src = SRC_W'($urandom_range(7, NUM_SOURCES_DEF));
            end else begin
                src = SRC_W'($urandom_range(NUM_SOURCES_DEF - 1));
            end
            send_request(cmd, src, random_level(), random_level());
        end
    endtask

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        write_swap_mask(6'h00);

        // stored levels start cleared, then clamp edges and code edges
        send_request(CMD_READ, 3'd0, 8'd0, 8'd0);
        send_request(CMD_SET, 3'd0, 8'd0, 8'd255);
        send_request(CMD_SET, 3'd1, 8'd100, 8'd101);
        send_request(CMD_SET, 3'd2, 8'd1, 8'd99);
        send_request(CMD_SET, 3'd3, 8'd255, 8'd0);
        send_request(CMD_SET, 3'd4, 8'd2, 8'd7);
        send_request(CMD_SET, 3'd5, 8'd50, 8'd3);
        // sources outside the mixer
        send_request(CMD_SET, 3'd6, 8'd10, 8'd20);
        send_request(CMD_READ, 3'd6, 8'd0, 8'd0);
        send_request(CMD_SET, 3'd7, 8'd255, 8'd255);
        send_request(CMD_READ, 3'd7, 8'd255, 8'd255);
        for (int s = 0; s < NUM_SOURCES_DEF; s++) begin
            send_request(CMD_READ, SRC_W'(s), 8'd0, 8'd0);
        end

        write_swap_mask(6'h3F);
        send_request(CMD_SET, 3'd0, 8'd100, 8'd0);
        send_request(CMD_SET, 3'd5, 8'd17, 8'd18);
        send_random(15);

        write_swap_mask(SWAP_W'($urandom_range(63)));
        quiet <= 1'b1;
        send_random(20);
        quiet <= 1'b0;

        // hold the sender until every write has come out
        wait_drained();
        send_random(15);

        write_swap_mask(SWAP_W'($urandom_range(63)));
        send_random(15);

        write_swap_mask(6'h00);
        send_random(15);

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatches == 0 && pending_writes == 0) begin
            $display("tb_stereo_volume_register_writer_unit: PASS");
        end else begin
            $display("tb_stereo_volume_register_writer_unit: FAIL");
        end
        $finish;
    end

endmodule
